@@ rtl/core/ddf_pkg.sv @@
package ddf_pkg;

  // Fixed field widths of the ports.
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 3;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Largest decimal digit.
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

endpackage

@@ rtl/core/decimal_digit_formatter.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+--------------------------
// command  | value, digit_count, show_zeros, pad_blank          | start high, busy low
// result   | ascii_char, last                                   | strobe, one cycle, no stall
//
// A word goes through bit-serial binary-to-BCD conversion (one input bit
// shifted in per cycle, add-3 correction on each BCD digit), then out one
// digit position of the clamped count per cycle; the next word is taken only
// once the controller is idle again. busy drops in the cycle
// that carries the final character; the receiver cannot stall, so nothing waits.
// rst is synchronous and returns the controller to idle with no strobe.
module decimal_digit_formatter #(
  parameter int MAX_DIGITS = 5,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ddf_pkg::VALUE_W-1:0]  value,
  input  logic [ddf_pkg::COUNT_W-1:0]  digit_count,
  input  logic                         show_zeros,
  input  logic                         pad_blank,
  output logic                         strobe,
  output logic [ddf_pkg::CHAR_W-1:0]   ascii_char,
  output logic                         last
);
  import ddf_pkg::*;

  localparam int BCD_W  = MAX_DIGITS * DIGIT_W;
  localparam int POS_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BITS_W = $clog2(VALUE_BITS + 1);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_DIGITS);
  localparam logic [BITS_W-1:0]  LAST_BIT  = BITS_W'(VALUE_BITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] bin_sr;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BITS_W-1:0]     bit_cnt;
  logic [POS_W-1:0]      pos;
  logic                  show;
  logic                  pad;
  logic                  seen;
  logic [COUNT_W-1:0]    count_clamped;
  logic [DIGIT_W-1:0]    digit;
  logic                  seen_next;
  logic                  suppress;

  // Clamp the requested digit count into 1..MAX_DIGITS.
  always_comb begin
    if (digit_count == '0) begin
      count_clamped = COUNT_W'(1);
    end else if (digit_count > MAX_COUNT) begin
      count_clamped = MAX_COUNT;
    end else begin
      count_clamped = digit_count;
    end
  end

  // Add-3 correction on every BCD digit that is five or more.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Current digit and whether it is a leading zero to suppress.
  assign digit     = bcd[pos*DIGIT_W +: DIGIT_W];
  assign seen_next = seen | (digit != '0);
  assign suppress  = !show && !seen_next && (pos != '0);
  assign busy      = (state != ST_IDLE);

  // Sequencer: load, shift in the binary word, then walk the digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            bin_sr  <= value[VALUE_BITS-1:0];
            bcd     <= '0;
            bit_cnt <= '0;
            pos     <= POS_W'(count_clamped - COUNT_W'(1));
            show    <= show_zeros;
            pad     <= pad_blank;
            seen    <= 1'b0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          strobe  <= 1'b0;
          // The top carry falls off, which keeps the value modulo 10^MAX_DIGITS.
          bcd     <= {bcd_adj[BCD_W-2:0], bin_sr[VALUE_BITS-1]};
          bin_sr  <= bin_sr << 1;
          bit_cnt <= bit_cnt + BITS_W'(1);
          if (bit_cnt == LAST_BIT) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          seen <= seen_next;
          last <= (pos == '0);
          if (suppress) begin
            strobe     <= pad;
            ascii_char <= CH_SPACE;
          end else begin
            strobe     <= 1'b1;
            ascii_char <= CH_ZERO + CHAR_W'(digit);
          end
          if (pos == '0) begin
            state <= ST_IDLE;
          end else begin
            pos <= pos - POS_W'(1);
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

  // A command is taken only when idle, and the block goes busy at once.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting a command");

  // No character leaves while the binary word is still being converted.
  a_conv_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !strobe)
    else $error("character strobed during conversion");

  // The final character of a number ends the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("character strobed after the final one");

  // Every character is a decimal digit or a space.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (ascii_char == CH_SPACE) ||
               ((ascii_char >= CH_ZERO) && (ascii_char <= CH_NINE)))
    else $error("illegal character code");

  // A space never ends a number.
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> (ascii_char != CH_SPACE) &&
                       (ascii_char - CH_ZERO <= CHAR_W'(DIGIT_MAX)))
    else $error("final character is not a digit");

endmodule
